// ===== src/assert_macros.svh =====
// Assertion macros shared by the RTL of the slew limiter.
// No dependencies; define NO_ASSERTIONS to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_IMPLY(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("implication check failed");

`define ASSERT_NEXT(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`else

`define ASSERT_IMPLY(label, ck, rn, ante, cons)

`define ASSERT_NEXT(label, ck, rn, ante, cons)

`endif

`endif

// ===== src/vds_pkg.sv =====
// Shared constants, types and register codes of the velocity slew limiter.
// No dependencies.
`timescale 1ns / 1ps

package vds_pkg;

    localparam int PCT_FRAC_BITS = 8;

    localparam int AXES   = 3;
    localparam int PCT_W  = 16;
    localparam int VEL_W  = 16;
    localparam int LIM_W  = 32;
    localparam int THR_W  = 15;
    localparam int STEP_W = 16;
    localparam int CFG_W  = 32;

    // Quotient of the scaling divide is at most 90 percent, so it fits PCT_FRAC_BITS + 7 bits.
    localparam int QUO_W = PCT_FRAC_BITS + 7;
    localparam int NUM_W = QUO_W + VEL_W;
    localparam int MAG_W = (QUO_W + 1 > THR_W + 1) ? QUO_W + 1 : THR_W + 1;
    localparam int CNT_W = $clog2(QUO_W + 1);
    localparam int SUM_W = PCT_W + 2;

    localparam logic [NUM_W-1:0] P90  = NUM_W'(90) << PCT_FRAC_BITS;
    localparam logic [MAG_W-1:0] P100 = MAG_W'(100) << PCT_FRAC_BITS;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_X_LIMITS   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_Y_LIMITS   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROT_LIMITS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_THROTTLE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEL      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DECEL      = 3'd5;

    localparam logic [LIM_W-1:0]  RST_X_LIMITS   = 32'd268435497;
    localparam logic [LIM_W-1:0]  RST_Y_LIMITS   = 32'd268435497;
    localparam logic [LIM_W-1:0]  RST_ROT_LIMITS = 32'd134217933;
    localparam logic [THR_W-1:0]  RST_THROTTLE   = 15'd10240;
    localparam logic [STEP_W-1:0] RST_ACCEL      = 16'd20480;
    localparam logic [STEP_W-1:0] RST_DECEL      = 16'd10240;

    localparam logic REQ_CMD  = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    typedef logic signed [PCT_W-1:0] pct_t;

    typedef struct packed {
        logic load;
        logic step;
        logic commit;
    } ramp_ctl_t;

endpackage

// ===== src/vds_scale_lane.sv =====
// One axis of the command scaler: deadband, linear map and a serial divider.
// Depends on vds_pkg.
`timescale 1ns / 1ps

module vds_scale_lane import vds_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [VEL_W-1:0] vel,
    input  logic [LIM_W-1:0]        limits,
    input  logic [THR_W-1:0]        throttle,
    output logic                    done,
    output pct_t                    pct
);

    localparam logic [1:0] L_IDLE = 2'd0;
    localparam logic [1:0] L_MUL  = 2'd1;
    localparam logic [1:0] L_DIV  = 2'd2;
    localparam logic [1:0] L_FIN  = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             done_reg, done_next;

    logic             neg_reg, below_reg, above_reg;
    logic [15:0]      diff_reg, den_reg, rem_reg;
    logic [QUO_W-1:0] low_reg, quo_reg;
    pct_t             pct_reg;

    logic [15:0]      max_spd, min_spd, mag;
    logic [VEL_W:0]   vel_ext, mag_ext;
    logic [NUM_W-1:0] num;
    logic [16:0]      trial, rem_sub;
    logic             ge;
    logic [QUO_W-1:0] quo_eff;
    logic [MAG_W-1:0] lin, thr_ext, mag_pct;
    logic [PCT_W-1:0] pct_u;
    pct_t             pct_signed;

    always_comb
    begin
        max_spd = limits[31:16];
        min_spd = limits[15:0];
        vel_ext = {vel[VEL_W-1], vel};
        mag_ext = vel[VEL_W-1] ? (~vel_ext + 17'd1) : vel_ext;
        mag     = mag_ext[15:0];

        // Round half up: the half divisor is added before the divide.
        num     = P90 * NUM_W'(diff_reg) + NUM_W'(den_reg >> 1);

        trial   = {rem_reg, low_reg[QUO_W-1]};
        ge      = trial >= {1'b0, den_reg};
        rem_sub = trial - {1'b0, den_reg};

        // Equal min and max speed leaves a zero divisor; the quotient is zero then.
        quo_eff = (den_reg == 16'd0) ? '0 : quo_reg;
        lin     = P100 - MAG_W'(quo_eff);
        thr_ext = MAG_W'(throttle);
        if (below_reg)
        begin
            mag_pct = '0;
        end
        else if (above_reg || lin > thr_ext)
        begin
            mag_pct = thr_ext;
        end
        else
        begin
            mag_pct = lin;
        end
        pct_u      = mag_pct[PCT_W-1:0];
        pct_signed = neg_reg ? -signed'(pct_u) : signed'(pct_u);
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        case (state_reg)
            L_IDLE:
            begin
                if (start)
                begin
                    state_next = L_MUL;
                end
            end
            L_MUL:
            begin
                cnt_next   = CNT_W'(QUO_W);
                state_next = L_DIV;
            end
            L_DIV:
            begin
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    state_next = L_FIN;
                end
            end
            L_FIN:
            begin
                done_next  = 1'b1;
                state_next = L_IDLE;
            end
            default:
            begin
                state_next = L_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= L_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            L_IDLE:
            begin
                if (start)
                begin
                    neg_reg   <= vel[VEL_W-1];
                    below_reg <= mag < min_spd;
                    above_reg <= mag > max_spd;
                    diff_reg  <= max_spd - mag;
                    den_reg   <= max_spd - min_spd;
                end
            end
            L_MUL:
            begin
                rem_reg <= num[NUM_W-1:QUO_W];
                low_reg <= num[QUO_W-1:0];
            end
            L_DIV:
            begin
                rem_reg <= ge ? rem_sub[15:0] : trial[15:0];
                low_reg <= {low_reg[QUO_W-2:0], 1'b0};
                quo_reg <= {quo_reg[QUO_W-2:0], ge};
            end
            L_FIN:
            begin
                pct_reg <= pct_signed;
            end
            default:
            begin
                pct_reg <= pct_reg;
            end
        endcase
    end

    assign done = done_reg;
    assign pct  = pct_reg;

endmodule

// ===== src/vds_ramp_lane.sv =====
// One axis of the slew limiter: target, previous target and ramp value.
// Depends on vds_pkg.
`timescale 1ns / 1ps

module vds_ramp_lane import vds_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  ramp_ctl_t         ctl,
    input  pct_t              tgt_in,
    input  logic [STEP_W-1:0] accel,
    input  logic [STEP_W-1:0] decel,
    output pct_t              ramp_next,
    output logic              done_next
);

    pct_t target_reg, old_reg, ramp_reg;

    logic                    up;
    logic [STEP_W-1:0]       step;
    logic signed [SUM_W-1:0] r_ext, t_ext, s_ext, sum;

    always_comb
    begin
        // Motion direction comes from the new target against the last settled one.
        up = target_reg > old_reg;
        if (up)
        begin
            step = (ramp_reg < 0) ? decel : accel;
        end
        else
        begin
            step = (ramp_reg > 0) ? decel : accel;
        end
        r_ext     = SUM_W'(ramp_reg);
        t_ext     = SUM_W'(target_reg);
        s_ext     = signed'({2'b00, step});
        sum       = up ? (r_ext + s_ext) : (r_ext - s_ext);
        done_next = up ? (sum > t_ext) : (sum < t_ext);
        ramp_next = done_next ? target_reg : pct_t'(sum[PCT_W-1:0]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg <= '0;
            old_reg    <= '0;
            ramp_reg   <= '0;
        end
        else
        begin
            if (ctl.load)
            begin
                target_reg <= tgt_in;
            end
            if (ctl.step)
            begin
                ramp_reg <= ramp_next;
            end
            if (ctl.commit)
            begin
                old_reg <= target_reg;
            end
        end
    end

endmodule

// ===== src/velocity_to_drive_slew_limiter_core.sv =====
// Top level of the velocity to drive slew limiter: three scale lanes, three
// ramp lanes, the merge of their done flags and the stream ports. Depends on vds_pkg.
//
//  channel  | signals                              | payload
//  ---------+--------------------------------------+------------------------------------
//  s_axis   | s_axis_tvalid/tready/tdata/tuser     | tuser req_type, tdata vel x/y/rot
//  m_axis   | m_axis_tvalid/tready/tdata/tlast     | tdata drive x/y/rot pct, tlast done
//  cfg      | cfg_valid/ready/index/data           | register index 0..5, value
//
// A command's duration is set by the serial restoring divider in each scale lane,
// one quotient bit a cycle; the lanes run in lockstep.
// A tick waits in S_TICK only while ramping and a pending result is not yet taken.
// One request is in the block at a time; s_axis_tready is high only while idle.
// Reset clears targets, ramp values, ramping and both handshakes; configuration is always taken.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module velocity_to_drive_slew_limiter_core import vds_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [47:0]          s_axis_tdata,   // vel_x, vel_y, vel_rot
    input  logic                 s_axis_tuser,   // req_type
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [47:0]          m_axis_tdata,   // drive_x_pct, drive_y_pct, drive_rot_pct
    output logic                 m_axis_tlast,   // ramp_done
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CMD  = 2'd1;
    localparam logic [1:0] S_TICK = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic              ramping_reg, ramping_next;
    logic              m_valid_reg, m_valid_next;
    logic [47:0]       m_data_reg;
    logic              m_last_reg;

    logic [LIM_W-1:0]  x_limits_reg, y_limits_reg, rot_limits_reg;
    logic [THR_W-1:0]  throttle_reg;
    logic [STEP_W-1:0] accel_reg, decel_reg;

    logic              in_fire, cmd_start, out_free, out_load, all_done, scale_all;
    logic [AXES-1:0]   scale_done, lane_done;
    logic [VEL_W-1:0]  lane_vel    [AXES];
    logic [LIM_W-1:0]  lane_limits [AXES];
    pct_t              lane_pct    [AXES];
    pct_t              lane_tgt    [AXES];
    pct_t              lane_ramp   [AXES];
    ramp_ctl_t         ramp_ctl;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign cfg_ready     = 1'b1;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign cmd_start     = in_fire && (s_axis_tuser == REQ_CMD);
    assign out_free      = !m_valid_reg || m_axis_tready;
    assign out_load      = (state_reg == S_TICK) && out_free && ramping_reg;
    assign scale_all     = &scale_done;
    assign all_done      = &lane_done;

    assign lane_vel[0]    = s_axis_tdata[15:0];
    assign lane_vel[1]    = s_axis_tdata[31:16];
    assign lane_vel[2]    = s_axis_tdata[47:32];
    assign lane_limits[0] = x_limits_reg;
    assign lane_limits[1] = y_limits_reg;
    assign lane_limits[2] = rot_limits_reg;

    // Drive frame: (y, -x, -rot).
    assign lane_tgt[0] = lane_pct[1];
    assign lane_tgt[1] = -lane_pct[0];
    assign lane_tgt[2] = -lane_pct[2];

    assign ramp_ctl.load   = (state_reg == S_CMD) && scale_all;
    assign ramp_ctl.step   = out_load;
    assign ramp_ctl.commit = out_load && all_done;

    for (genvar g = 0; g < AXES; g++)
    begin : g_lane
        vds_scale_lane u_scale
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .start    (cmd_start),
            .vel      (lane_vel[g]),
            .limits   (lane_limits[g]),
            .throttle (throttle_reg),
            .done     (scale_done[g]),
            .pct      (lane_pct[g])
        );

        vds_ramp_lane u_ramp
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl       (ramp_ctl),
            .tgt_in    (lane_tgt[g]),
            .accel     (accel_reg),
            .decel     (decel_reg),
            .ramp_next (lane_ramp[g]),
            .done_next (lane_done[g])
        );
    end

    always_comb
    begin
        state_next   = state_reg;
        ramping_next = ramping_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = (s_axis_tuser == REQ_CMD) ? S_CMD : S_TICK;
                end
            end
            S_CMD:
            begin
                if (scale_all)
                begin
                    ramping_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_TICK:
            begin
                // An idle tick finishes at once; a ramp tick waits for the output slot.
                if (!ramping_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (out_free)
                begin
                    state_next = S_IDLE;
                    if (all_done)
                    begin
                        ramping_next = 1'b0;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (out_load)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end
        else
        begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            ramping_reg    <= 1'b0;
            m_valid_reg    <= 1'b0;
            x_limits_reg   <= RST_X_LIMITS;
            y_limits_reg   <= RST_Y_LIMITS;
            rot_limits_reg <= RST_ROT_LIMITS;
            throttle_reg   <= RST_THROTTLE;
            accel_reg      <= RST_ACCEL;
            decel_reg      <= RST_DECEL;
        end
        else
        begin
            state_reg   <= state_next;
            ramping_reg <= ramping_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_X_LIMITS:   x_limits_reg   <= cfg_data;
                    REG_Y_LIMITS:   y_limits_reg   <= cfg_data;
                    REG_ROT_LIMITS: rot_limits_reg <= cfg_data;
                    REG_THROTTLE:   throttle_reg   <= cfg_data[THR_W-1:0];
                    REG_ACCEL:      accel_reg      <= cfg_data[STEP_W-1:0];
                    REG_DECEL:      decel_reg      <= cfg_data[STEP_W-1:0];
                    default:        throttle_reg   <= throttle_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            m_data_reg <= {lane_ramp[2], lane_ramp[1], lane_ramp[0]};
            m_last_reg <= all_done;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tlast  = m_last_reg;

    `ASSERT_IMPLY(a_lanes_lockstep, clk, rst_n, |scale_done, scale_all)
    `ASSERT_IMPLY(a_out_needs_ramp, clk, rst_n, out_load, ramping_reg && !ramp_ctl.load)
    `ASSERT_NEXT(a_done_ends_ramp, clk, rst_n, out_load && all_done, !ramping_reg && m_axis_tvalid && m_axis_tlast)
    `ASSERT_NEXT(a_accept_goes_busy, clk, rst_n, in_fire, !s_axis_tready)

endmodule
